/* rtl/cslx_pkg.sv */
// Shared types, kind codes and character classes for the C subset lexer.
// No dependencies; imported by c_subset_lexer.
`default_nettype none
package cslx_pkg;

	localparam int POSITION_BITS_DEF = 16;
	localparam int PREFIX_LEN        = 6;
	localparam logic [15:0] OUT_MAX  = 16'hFFFF;

	typedef logic [4:0] kind_t;

	localparam kind_t KIND_IDENT  = 5'd0;
	localparam kind_t KIND_NUMBER = 5'd1;
	localparam kind_t KIND_INT    = 5'd2;
	localparam kind_t KIND_FLOAT  = 5'd3;
	localparam kind_t KIND_IF     = 5'd4;
	localparam kind_t KIND_ELSE   = 5'd5;
	localparam kind_t KIND_WHILE  = 5'd6;
	localparam kind_t KIND_FOR    = 5'd7;
	localparam kind_t KIND_RETURN = 5'd8;
	localparam kind_t KIND_VOID   = 5'd9;
	localparam kind_t KIND_PLUS   = 5'd10;
	localparam kind_t KIND_MINUS  = 5'd11;
	localparam kind_t KIND_STAR   = 5'd12;
	localparam kind_t KIND_SLASH  = 5'd13;
	localparam kind_t KIND_ASSIGN = 5'd14;
	localparam kind_t KIND_EQUAL  = 5'd15;
	localparam kind_t KIND_LPAREN = 5'd16;
	localparam kind_t KIND_RPAREN = 5'd17;
	localparam kind_t KIND_LBRACE = 5'd18;
	localparam kind_t KIND_RBRACE = 5'd19;
	localparam kind_t KIND_SEMI   = 5'd20;
	localparam kind_t KIND_COMMA  = 5'd21;

	typedef enum logic [1:0] {
		MODE_IDLE   = 2'd0,
		MODE_IDENT  = 2'd1,
		MODE_NUMBER = 2'd2,
		MODE_EQWAIT = 2'd3
	} mode_t;

	// byte 0 of the identifier sits in the most significant byte
	typedef logic [0:PREFIX_LEN-1][7:0] prefix_t;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] start;
		logic [15:0] length;
		logic        last;
	} tok_t;

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_ident_start(input logic [7:0] c);
		return is_letter(c) || c == "_";
	endfunction

	function automatic logic is_ident_char(input logic [7:0] c);
		return is_ident_start(c) || is_digit(c);
	endfunction

	// KIND_IDENT here means not a single-byte operator
	function automatic kind_t single_kind(input logic [7:0] c);
		kind_t k;
		case (c)
			"+": k = KIND_PLUS;
			"-": k = KIND_MINUS;
			"*": k = KIND_STAR;
			"/": k = KIND_SLASH;
			"(": k = KIND_LPAREN;
			")": k = KIND_RPAREN;
			"{": k = KIND_LBRACE;
			"}": k = KIND_RBRACE;
			";": k = KIND_SEMI;
			",": k = KIND_COMMA;
			default: k = KIND_IDENT;
		endcase
		return k;
	endfunction

	// short: identifier is at most six bytes; len3 holds its length then
	function automatic kind_t ident_kind(input logic short, input logic [2:0] len3,
			input prefix_t p);
		kind_t k;
		k = KIND_IDENT;
		if (short) begin
			if (len3 == 3'd3 && p == {"int", 24'd0})         k = KIND_INT;
			else if (len3 == 3'd5 && p == {"float", 8'd0})   k = KIND_FLOAT;
			else if (len3 == 3'd2 && p == {"if", 32'd0})     k = KIND_IF;
			else if (len3 == 3'd4 && p == {"else", 16'd0})   k = KIND_ELSE;
			else if (len3 == 3'd5 && p == {"while", 8'd0})   k = KIND_WHILE;
			else if (len3 == 3'd3 && p == {"for", 24'd0})    k = KIND_FOR;
			else if (len3 == 3'd6 && p == "return")          k = KIND_RETURN;
			else if (len3 == 3'd4 && p == {"void", 16'd0})   k = KIND_VOID;
		end
		return k;
	endfunction

endpackage
`default_nettype wire

/* rtl/c_subset_lexer.sv */
// A byte is registered at accept and its tokens are written to the output queue once the queue
// has room for them; the queue offers the first of them at once.
// Throughput: one byte per cycle while the queue holds at most two tokens; tokens leave one at a
// time through the single result port behind the four-entry token queue.
// Reset clears scan mode, offsets, prefix and the queue.
// Top level of the C subset lexer; depends on cslx_pkg.
`default_nettype none
module c_subset_lexer #(
	parameter int POSITION_BITS = cslx_pkg::POSITION_BITS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [7:0]          char_byte,
	input  wire logic                end_of_source,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output cslx_pkg::kind_t          token_kind,
	output logic [15:0]              token_start,
	output logic [15:0]              token_length,
	output logic                     last_of_run
);
	import cslx_pkg::*;

	localparam int P  = POSITION_BITS;
	localparam int CW = (P > 16) ? P : 16;

	function automatic logic [15:0] clamp16(input logic [P-1:0] v);
		logic [CW-1:0] w;
		w = CW'(v);
		if (w > CW'(OUT_MAX)) return OUT_MAX;
		else return w[15:0];
	endfunction

	// input register
	logic       valid_s1;
	logic [7:0] char_s1;
	logic       eos_s1;

	// scan state
	mode_t          mode_q, mode_d;
	logic [P-1:0]   offset_q, offset_d;
	logic [P-1:0]   pstart_q, pstart_d;
	logic [P-1:0]   plen_q, plen_d;
	prefix_t        prefix_q, prefix_d;

	// token queue
	tok_t       fifo_q [4];
	logic [1:0] wr_q, rd_q;
	logic [2:0] cnt_q;

	logic room, fire, pop;
	assign room     = cnt_q <= 3'd2;
	assign fire     = valid_s1 && room;
	assign in_ready = !valid_s1 || room;
	assign pop      = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			char_s1 <= char_byte;
			eos_s1  <= end_of_source;
		end
	end

	// next state and the first two token candidates
	logic  emit_a, emit_b;
	kind_t kind_a, kind_b;
	logic [P-1:0] start_a;
	logic [15:0]  len_a;
	logic  consumed;
	mode_t mode_m;
	logic [2:0] idx;

	assign idx = plen_q[2:0];

	always_comb begin
		mode_m   = mode_q;
		pstart_d = pstart_q;
		plen_d   = plen_q;
		prefix_d = prefix_q;
		emit_a   = 1'b0;
		kind_a   = KIND_IDENT;
		start_a  = pstart_q;
		len_a    = clamp16(plen_q);
		emit_b   = 1'b0;
		kind_b   = single_kind(char_s1);
		consumed = 1'b0;

		if (mode_q == MODE_IDENT && is_ident_char(char_s1)) begin
			if (plen_q < P'(PREFIX_LEN)) prefix_d[idx] = char_s1;
			if (plen_q != '1) plen_d = plen_q + 1'b1;
			consumed = 1'b1;
		end else if (mode_q == MODE_NUMBER && is_digit(char_s1)) begin
			if (plen_q != '1) plen_d = plen_q + 1'b1;
			consumed = 1'b1;
		end else if (mode_q == MODE_EQWAIT && char_s1 == "=") begin
			emit_a   = 1'b1;
			kind_a   = KIND_EQUAL;
			len_a    = 16'd2;
			mode_m   = MODE_IDLE;
			consumed = 1'b1;
		end else begin
			// flush the pending token
			case (mode_q)
				MODE_IDENT: begin
					emit_a = 1'b1;
					kind_a = ident_kind(plen_q <= P'(PREFIX_LEN), idx, prefix_q);
				end
				MODE_NUMBER: begin
					emit_a = 1'b1;
					kind_a = KIND_NUMBER;
				end
				MODE_EQWAIT: begin
					emit_a = 1'b1;
					kind_a = KIND_ASSIGN;
				end
				default: emit_a = 1'b0;
			endcase
			mode_m = MODE_IDLE;
		end

		if (!consumed) begin
			if (is_ident_start(char_s1) || is_digit(char_s1) || char_s1 == "=") begin
				if (is_ident_start(char_s1))  mode_m = MODE_IDENT;
				else if (is_digit(char_s1))   mode_m = MODE_NUMBER;
				else                          mode_m = MODE_EQWAIT;
				pstart_d    = offset_q;
				plen_d      = P'(1);
				prefix_d    = '0;
				prefix_d[0] = char_s1;
			end else if (kind_b != KIND_IDENT) begin
				emit_b = 1'b1;
			end
		end

		offset_d = (offset_q != '1) ? offset_q + 1'b1 : offset_q;
		mode_d   = mode_m;
		if (eos_s1) begin
			mode_d   = MODE_IDLE;
			offset_d = '0;
		end
	end

	// end-of-source flush and ordering of the tokens
	logic  emit_c;
	kind_t kind_c;
	tok_t  tok_a, tok_b, tok_c, r0, r1;
	logic [1:0] push_n;

	always_comb begin
		emit_c = 1'b0;
		kind_c = KIND_IDENT;
		if (eos_s1) begin
			case (mode_m)
				MODE_IDENT: begin
					emit_c = 1'b1;
					kind_c = ident_kind(plen_d <= P'(PREFIX_LEN), plen_d[2:0], prefix_d);
				end
				MODE_NUMBER: begin
					emit_c = 1'b1;
					kind_c = KIND_NUMBER;
				end
				MODE_EQWAIT: begin
					emit_c = 1'b1;
					kind_c = KIND_ASSIGN;
				end
				default: emit_c = 1'b0;
			endcase
		end

		tok_a = '{kind: kind_a, start: clamp16(start_a), length: len_a, last: 1'b0};
		tok_b = '{kind: kind_b, start: clamp16(offset_q), length: 16'd1, last: 1'b0};
		tok_c = '{kind: kind_c, start: clamp16(pstart_d), length: clamp16(plen_d),
			last: 1'b0};

		r1 = tok_c;
		if (emit_a) begin
			r0 = tok_a;
			r1 = emit_b ? tok_b : tok_c;
		end else if (emit_b) begin
			r0 = tok_b;
		end else begin
			r0 = tok_c;
		end
		push_n = 2'(emit_a) + 2'(emit_b) + 2'(emit_c);
		r0.last = (push_n == 2'd1);
		r1.last = 1'b1;
		if (!fire) push_n = 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_IDLE;
			offset_q <= '0;
			pstart_q <= '0;
			plen_q   <= '0;
			prefix_q <= '0;
		end else if (fire) begin
			mode_q   <= mode_d;
			offset_q <= offset_d;
			pstart_q <= pstart_d;
			plen_q   <= plen_d;
			prefix_q <= prefix_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + push_n;
			rd_q  <= rd_q + 2'(pop);
			cnt_q <= cnt_q + 3'(push_n) - 3'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) fifo_q[wr_q] <= r0;
		if (push_n == 2'd2) fifo_q[wr_q + 2'd1] <= r1;
	end

	assign out_valid    = cnt_q != 3'd0;
	assign token_kind   = fifo_q[rd_q].kind;
	assign token_start  = fifo_q[rd_q].start;
	assign token_length = fifo_q[rd_q].length;
	assign last_of_run  = fifo_q[rd_q].last;

endmodule
`default_nettype wire
